// ===== sv/asfw_pkg.sv =====
// Shared types and constants for the audio sample FIFO with water marks.
package asfw_pkg;

  // Request kinds carried in the slave tuser.
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Result codes carried in the master tuser.
  typedef enum logic [2:0] {
    ST_SAMPLE    = 3'd0,
    ST_EMPTY_OK  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_PUSH_OK   = 3'd3,
    ST_STALE     = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_FLUSHED   = 3'd6,
    ST_RSVD      = 3'd7
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RATE  = 2'd0,
    CFG_CHANS = 2'd1,
    CFG_LOW   = 2'd2,
    CFG_HIGH  = 2'd3
  } cfg_idx_e;

  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned PopW     = 7;
  localparam int unsigned RateW    = 18;
  localparam int unsigned ChansW   = 2;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ThrW     = RateW + MsW;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned CfgDataW = 18;

  localparam logic [RateW-1:0]  RateReset  = 18'd48000;
  localparam logic [ChansW-1:0] ChansReset = 2'd2;
  localparam logic [MsW-1:0]    LowReset   = 16'd0;
  localparam logic [MsW-1:0]    HighReset  = 16'd1000;
  localparam logic [9:0]        MsPerSec   = 10'd1000;

endpackage

// ===== sv/audio_sample_fifo_watermarks_top.sv =====
// Audio sample FIFO top level: one-port sample memory, pointers, counters and output register.
// Push, flush and refused items give their single result through the pending and output
// registers and can be accepted back to back, one item per cycle while the output is free.
// A pop of N samples passes through the read data and output registers, one sample per cycle
// while not stalled; the next item is taken once the last sample has left the read stage.
// Reset at once clears pointers, level, generation, counters, configuration, sequencing and
// output valid; the sample memory, read data and output data registers are not cleared.
module audio_sample_fifo_watermarks_top
  import asfw_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4096,
  parameter int unsigned MAX_POP    = 64,
  localparam int unsigned LvlW      = $clog2(FIFO_DEPTH + 1),
  localparam int unsigned OutDataW  = ((3 * CountW + WordW + CountW + LvlW + 3) + 7) / 8 * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Slave word: tdata = sample_word, gen_tag, pop_count, zero pad; tuser = req_type.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  // Master word: tdata = sample_out, level_samples, generation, primed, below_low,
  // above_high, underflows, pushed_total, popped_total, zero pad; tuser = status.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,
  output logic [2:0]           m_axis_tuser,
  output logic                 m_axis_tlast,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(MAX_POP + 1);
  localparam int unsigned CmpW = (LvlW > PopW) ? LvlW : PopW;

  // Configuration registers and registered water-mark thresholds.
  logic [RateW-1:0]  rate_q;
  logic [ChansW-1:0] chans_q;
  logic [MsW-1:0]    low_ms_q, high_ms_q;
  logic [ThrW-1:0]   low_thr_q, high_thr_q;

  // FIFO state.
  logic [PtrW-1:0]   rp_q, rp_d, wp_q, wp_d;
  logic [LvlW-1:0]   level_q, level_d;
  logic [CountW-1:0] gen_q, gen_d;
  logic              primed_q, primed_d;
  logic [CountW-1:0] under_q, under_d, pushed_q, pushed_d, popped_q, popped_d;

  // Sequencing.
  logic              pend_q, pend_d;
  status_e           pend_st_q, pend_st_d;
  logic [CntW-1:0]   remain_q, remain_d;
  logic              rd_valid_q, rd_valid_d;
  logic              rd_last_q, rd_last_d;
  logic [WordW-1:0]  rdata_q;
  logic [WordW-1:0]  sample_mem [FIFO_DEPTH];

  // Output register.
  logic              out_valid_q;
  status_e           out_st_q;
  logic [WordW-1:0]  out_sample_q;
  logic              out_last_q;
  logic [LvlW-1:0]   out_level_q;
  logic [CountW-1:0] out_gen_q, out_under_q, out_pushed_q, out_popped_q;
  logic              out_primed_q, out_below_q, out_above_q;

  // Decoded input word.
  req_e              req;
  logic [WordW-1:0]  in_word;
  logic [CountW-1:0] in_egen;
  logic [PopW-1:0]   in_cnt, cnt_clamped;
  logic [WordW-1:0]  store_word;

  logic              in_acc, out_free, load_single, move, rd_issue, mem_we;
  logic              pop_busy;
  logic [CountW:0]   pushed_sum, popped_sum, under_sum;
  logic [LvlW+9:0]   lvl1000;
  logic              below, above;

  assign req         = req_e'(s_axis_tuser);
  assign in_word     = s_axis_tdata[WordW-1:0];
  assign in_egen     = s_axis_tdata[WordW +: CountW];
  assign in_cnt      = s_axis_tdata[WordW+CountW +: PopW];
  assign cnt_clamped = (in_cnt > PopW'(MAX_POP)) ? PopW'(MAX_POP) : in_cnt;
  assign store_word  = (chans_q == 2'd1) ? {16'h0000, in_word[15:0]} : in_word;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign load_single = pend_q && out_free;
  assign move        = rd_valid_q && out_free;
  assign rd_issue    = (remain_q != '0) && (!rd_valid_q || move);
  assign pop_busy    = (remain_q != '0) || rd_valid_q;

  // A pending single result may leave in the same cycle that the next item arrives.
  assign s_axis_tready = !pop_busy && (!pend_q || out_free);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign pushed_sum = {1'b0, pushed_q} + 33'd1;
  assign under_sum  = {1'b0, under_q} + 33'd1;
  assign popped_sum = {1'b0, popped_q} + 33'(cnt_clamped);

  // Item decode and state update.
  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    level_d   = level_q;
    gen_d     = gen_q;
    primed_d  = primed_q;
    under_d   = under_q;
    pushed_d  = pushed_q;
    popped_d  = popped_q;
    pend_d    = pend_q && !load_single;
    pend_st_d = pend_st_q;
    remain_d  = remain_q;
    mem_we    = 1'b0;

    if (rd_issue) begin
      rp_d     = (rp_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      remain_d = remain_q - 1'b1;
    end

    if (in_acc) begin
      case (req)
        REQ_PUSH: begin
          pend_d = 1'b1;
          if (in_egen != '0 && in_egen != gen_q) begin
            pend_st_d = ST_STALE;
          end else if (level_q >= LvlW'(FIFO_DEPTH)) begin
            pend_st_d = ST_OVERFLOW;
          end else begin
            pend_st_d = ST_PUSH_OK;
            mem_we    = 1'b1;
            wp_d      = (wp_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
            level_d   = level_q + 1'b1;
            pushed_d  = pushed_sum[CountW] ? '1 : pushed_sum[CountW-1:0];
            primed_d  = 1'b1;
          end
        end
        REQ_POP: begin
          if (cnt_clamped == '0) begin
            pend_d    = 1'b1;
            pend_st_d = ST_EMPTY_OK;
          end else if (CmpW'(level_q) < CmpW'(cnt_clamped)) begin
            pend_d    = 1'b1;
            pend_st_d = ST_UNDERFLOW;
            under_d   = under_sum[CountW] ? '1 : under_sum[CountW-1:0];
          end else begin
            level_d  = level_q - LvlW'(cnt_clamped);
            popped_d = popped_sum[CountW] ? '1 : popped_sum[CountW-1:0];
            remain_d = CntW'(cnt_clamped);
          end
        end
        REQ_FLUSH: begin
          pend_d    = 1'b1;
          pend_st_d = ST_FLUSHED;
          gen_d     = gen_q + 1'b1;
          rp_d      = '0;
          wp_d      = '0;
          level_d   = '0;
          primed_d  = 1'b0;
          under_d   = '0;
          pushed_d  = '0;
          popped_d  = '0;
        end
        default: ;
      endcase
    end
  end

  // Read stage: the read data register holds while its word waits for the output register.
  always_comb begin
    rd_valid_d = rd_valid_q;
    rd_last_d  = rd_last_q;
    if (rd_issue) begin
      rd_valid_d = 1'b1;
      rd_last_d  = (remain_q == CntW'(1));
    end else if (move) begin
      rd_valid_d = 1'b0;
    end
  end

  // Water-mark flags from the level held after the item.
  assign lvl1000 = level_q * MsPerSec;
  assign below   = primed_q && (rate_q != '0) && (ThrW'(lvl1000) < low_thr_q);
  assign above   = (rate_q != '0) && (ThrW'(lvl1000) >= high_thr_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sample_mem[wp_q] <= store_word;
    end
    if (rd_issue) begin
      rdata_q <= sample_mem[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= RateReset;
      chans_q    <= ChansReset;
      low_ms_q   <= LowReset;
      high_ms_q  <= HighReset;
      low_thr_q  <= '0;
      high_thr_q <= ThrW'(HighReset) * ThrW'(RateReset);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_RATE:  rate_q    <= cfg_data_i[RateW-1:0];
          CFG_CHANS: chans_q   <= cfg_data_i[ChansW-1:0];
          CFG_LOW:   low_ms_q  <= cfg_data_i[MsW-1:0];
          CFG_HIGH:  high_ms_q <= cfg_data_i[MsW-1:0];
          default: ;
        endcase
      end
      low_thr_q  <= low_ms_q * rate_q;
      high_thr_q <= high_ms_q * rate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q       <= '0;
      wp_q       <= '0;
      level_q    <= '0;
      gen_q      <= '0;
      primed_q   <= 1'b0;
      under_q    <= '0;
      pushed_q   <= '0;
      popped_q   <= '0;
      pend_q     <= 1'b0;
      pend_st_q  <= ST_SAMPLE;
      remain_q   <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      level_q    <= level_d;
      gen_q      <= gen_d;
      primed_q   <= primed_d;
      under_q    <= under_d;
      pushed_q   <= pushed_d;
      popped_q   <= popped_d;
      pend_q     <= pend_d;
      pend_st_q  <= pend_st_d;
      remain_q   <= remain_d;
      rd_valid_q <= rd_valid_d;
      rd_last_q  <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_single || move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Status fields always come from the current state, which already reflects the item.
  always_ff @(posedge clk_i) begin
    if (load_single || move) begin
      out_st_q     <= load_single ? pend_st_q : ST_SAMPLE;
      out_sample_q <= load_single ? '0 : rdata_q;
      out_last_q   <= load_single ? 1'b1 : rd_last_q;
      out_level_q  <= level_q;
      out_gen_q    <= gen_q;
      out_primed_q <= primed_q;
      out_below_q  <= below;
      out_above_q  <= above;
      out_under_q  <= under_q;
      out_pushed_q <= pushed_q;
      out_popped_q <= popped_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OutDataW'({out_popped_q, out_pushed_q, out_under_q, out_above_q,
                                    out_below_q, out_primed_q, out_gen_q, out_level_q,
                                    out_sample_q});

endmodule

// ===== sv/asfw_checker.sv =====
// Port-level checks for the audio sample FIFO, bound to its top level.
module asfw_checker
  import asfw_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4096,
  localparam int unsigned LvlW      = $clog2(FIFO_DEPTH + 1),
  localparam int unsigned OutDataW  = ((3 * CountW + WordW + CountW + LvlW + 3) + 7) / 8 * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [2:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  localparam int unsigned PrimedBit = WordW + LvlW + CountW;
  localparam int unsigned BelowBit  = PrimedBit + 1;

  logic [LvlW-1:0] level;
  assign level = m_axis_tdata[WordW +: LvlW];

  // A word that is held back stays unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Every result other than a popped sample is the only result of its item.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_SAMPLE) |-> m_axis_tlast)
    else $error("single result without last");

  // The low-water flag is never raised before the FIFO has been primed.
  a_low_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[BelowBit] |-> m_axis_tdata[PrimedBit])
    else $error("below_low without primed");

  // The reported level never exceeds the storage depth.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> level <= LvlW'(FIFO_DEPTH))
    else $error("level beyond depth");

endmodule

bind audio_sample_fifo_watermarks_top asfw_checker #(
  .FIFO_DEPTH(FIFO_DEPTH)
) u_asfw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ===== sim/audio_fifo_checker.sv =====
`timescale 1ns / 100ps
// Checker for the audio sample FIFO: follows every channel, predicts the result words and compares them.
module audio_fifo_checker
  import asfw_pkg::*;
#(
  parameter int unsigned FifoDepth = 4096,
  parameter int unsigned MaxPop    = 64,
  parameter int unsigned ResultW   = 176
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [1:0]          s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [ResultW-1:0]  m_tdata_i,
  input  logic [2:0]          m_tuser_i,
  input  logic                m_tlast_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct {
    status_e     status;
    logic [31:0] sample;
    logic        last;
    logic [12:0] level;
    logic [31:0] gen;
    logic        primed;
    logic        below;
    logic        above;
    logic [31:0] underflows;
    logic [31:0] pushed;
    logic [31:0] popped;
  } fifo_result_t;

  fifo_result_t predicted_words[$];
  int           fails;

  // Shadow copy of the FIFO and its settings.
  logic [31:0]       sample_mem[FifoDepth];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       level;
  logic [31:0]       gen;
  logic              primed;
  logic [31:0]       underflows;
  logic [31:0]       pushed;
  logic [31:0]       popped;
  logic [RateW-1:0]  rate_hz;
  logic [ChansW-1:0] chans;
  logic [MsW-1:0]    low_ms;
  logic [MsW-1:0]    high_ms;

  function automatic logic [31:0] sat_inc(input logic [31:0] a, input int unsigned b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? '1 : s[31:0];
  endfunction

  // Every word reports the state after its request has been applied.
  task automatic expect_word(input status_e st, input logic [31:0] w, input logic last);
    fifo_result_t r;
    longint       lvl1000;
    lvl1000      = longint'(level) * longint'(MsPerSec);
    r.status     = st;
    r.sample     = w;
    r.last       = last;
    r.level      = level[12:0];
    r.gen        = gen;
    r.primed     = primed;
    r.below      = primed && rate_hz != 0 && lvl1000 < longint'(low_ms) * longint'(rate_hz);
    r.above      = rate_hz != 0 && lvl1000 >= longint'(high_ms) * longint'(rate_hz);
    r.underflows = underflows;
    r.pushed     = pushed;
    r.popped     = popped;
    predicted_words = {predicted_words, r};
  endtask

  task automatic apply_request(input req_e req, input logic [31:0] word,
                               input logic [31:0] tag, input logic [6:0] cnt);
    int unsigned n;
    case (req)
      REQ_PUSH: begin
        // The generation tag is checked before fullness.
        if (tag != 0 && tag != gen) begin
          expect_word(ST_STALE, '0, 1'b1);
        end else if (level >= FifoDepth) begin
          expect_word(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (chans == 2'd1) word[31:16] = '0;
          sample_mem[wr_ptr] = word;
          wr_ptr = (wr_ptr + 1) % FifoDepth;
          level++;
          pushed = sat_inc(pushed, 1);
          primed = 1'b1;
          expect_word(ST_PUSH_OK, '0, 1'b1);
        end
      end
      REQ_POP: begin
        n = (cnt > MaxPop) ? MaxPop : cnt;
        if (n == 0) begin
          expect_word(ST_EMPTY_OK, '0, 1'b1);
        end else if (level < n) begin
          underflows = sat_inc(underflows, 1);
          expect_word(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          level -= n;
          popped = sat_inc(popped, n);
          for (int unsigned i = 0; i < n; i++) begin
            expect_word(ST_SAMPLE, sample_mem[rd_ptr], i + 1 == n);
            rd_ptr = (rd_ptr + 1) % FifoDepth;
          end
        end
      end
      REQ_FLUSH: begin
        gen++;
        rd_ptr     = 0;
        wr_ptr     = 0;
        level      = 0;
        primed     = 1'b0;
        underflows = '0;
        pushed     = '0;
        popped     = '0;
        expect_word(ST_FLUSHED, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_word();
    fifo_result_t want;
    if (predicted_words.size() == 0) begin
      $error("result word with status %0d arrived while none was expected", m_tuser_i);
      fails++;
    end else begin
      want = predicted_words[0];
      predicted_words.delete(0);
      compare_field("status", 32'(want.status), 32'(m_tuser_i));
      compare_field("sample_out", want.sample, m_tdata_i[31:0]);
      compare_field("last_sample", 32'(want.last), 32'(m_tlast_i));
      compare_field("level_samples", 32'(want.level), 32'(m_tdata_i[44:32]));
      compare_field("generation", want.gen, m_tdata_i[76:45]);
      compare_field("primed", 32'(want.primed), 32'(m_tdata_i[77]));
      compare_field("below_low", 32'(want.below), 32'(m_tdata_i[78]));
      compare_field("above_high", 32'(want.above), 32'(m_tdata_i[79]));
      compare_field("underflows", want.underflows, m_tdata_i[111:80]);
      compare_field("pushed_total", want.pushed, m_tdata_i[143:112]);
      compare_field("popped_total", want.popped, m_tdata_i[175:144]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_words.delete();
      fails        = 0;
      rd_ptr       = 0;
      wr_ptr       = 0;
      level        = 0;
      gen          = '0;
      primed       = 1'b0;
      underflows   = '0;
      pushed       = '0;
      popped       = '0;
      rate_hz      = RateReset;
      chans        = ChansReset;
      low_ms       = LowReset;
      high_ms      = HighReset;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Outputs first: a word leaving now never belongs to a request taken at this edge.
      if (m_tvalid_i && m_tready_i) check_word();
      if (s_tvalid_i && s_tready_i) begin
        apply_request(req_e'(s_tuser_i), s_tdata_i[31:0], s_tdata_i[63:32], s_tdata_i[70:64]);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_RATE:  rate_hz = cfg_data_i[RateW-1:0];
          CFG_CHANS: chans   = cfg_data_i[ChansW-1:0];
          CFG_LOW:   low_ms  = cfg_data_i[MsW-1:0];
          CFG_HIGH:  high_ms = cfg_data_i[MsW-1:0];
          default: begin
          end
        endcase
      end
      pending_o    <= predicted_words.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== sim/audio_sample_fifo_watermarks_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the audio sample FIFO: clock, reset, stimulus phases and the final verdict.
module audio_sample_fifo_watermarks_top_tb;
  import asfw_pkg::*;

  localparam int unsigned FifoDepth = 4096;
  localparam int unsigned MaxPop    = 64;
  localparam int unsigned ResultW   = 176;

  logic clk = 1'b0;
  logic rst_n;

  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [ResultW-1:0]  m_tdata;
  logic [2:0]          m_tuser;
  logic                m_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int flushes     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  audio_sample_fifo_watermarks_top #(
    .FIFO_DEPTH(FifoDepth),
    .MAX_POP   (MaxPop)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  audio_fifo_checker #(
    .FifoDepth(FifoDepth),
    .MaxPop   (MaxPop),
    .ResultW  (ResultW)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .m_tlast_i   (m_tlast),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Valid stays high from one word to the next unless the sender idles in between.
  task automatic send_item(input req_e req, input logic [31:0] word, input logic [31:0] tag,
                           input logic [6:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, cnt, tag, word};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    if (req == REQ_FLUSH) flushes++;
  endtask

  // Mostly matching or wildcard tags, sometimes an arbitrary one.
  function automatic logic [31:0] pick_tag();
    int r;
    r = $urandom_range(99);
    if (r < 45) return '0;
    if (r < 90) return 32'(flushes);
    return $urandom;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // Leaves room for an ignored request or a pop still in flight.
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input int unsigned rate, input int unsigned chans,
                             input int unsigned low, input int unsigned high);
    drain();
    cfg_put(CFG_RATE, CfgDataW'(rate));
    cfg_put(CFG_CHANS, CfgDataW'(chans));
    cfg_put(CFG_LOW, CfgDataW'(low));
    cfg_put(CFG_HIGH, CfgDataW'(high));
    cfg_valid <= 1'b0;
  endtask

  // Bursts of pushes followed by pops, with stray requests of any kind in between.
  task automatic run_mixed(input int items);
    int   sent;
    int   k;
    req_e stray;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(1, 32);
        repeat (k) send_item(REQ_PUSH, $urandom, pick_tag(), 7'($urandom_range(127)));
        sent += k;
        k = $urandom_range(1, 4);
        repeat (k) send_item(REQ_POP, $urandom, $urandom, 7'($urandom_range(1, 16)));
        sent += k;
      end else begin
        stray = req_e'($urandom_range(3));
        send_item(stray, $urandom, pick_tag(), 7'($urandom_range(127)));
        if (stray != REQ_NONE) sent++;
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= REQ_PUSH;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RATE;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 37;
    rx_idle_pct = 84;
    send_item(REQ_POP, 32'h0, 32'h0, 7'd0);
    send_item(REQ_POP, 32'h0, 32'h0, 7'd1);
    send_item(REQ_PUSH, 32'hFFFF_FFFF, 32'h0, 7'd0);
    send_item(REQ_PUSH, 32'h0, 32'h0, 7'h7F);
    send_item(REQ_PUSH, 32'h1234_5678, 32'd5, 7'd0);
    send_item(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    send_item(REQ_POP, 32'h0, 32'h0, 7'd2);
    send_item(REQ_FLUSH, 32'h0, 32'h0, 7'd0);
    send_item(REQ_PUSH, 32'hA5A5_5A5A, 32'd1, 7'd0);
    send_item(REQ_PUSH, 32'h0, 32'hFFFF_FFFF, 7'd0);
    send_item(REQ_POP, 32'h0, 32'h0, 7'h7F);
    repeat (3) send_item(REQ_PUSH, $urandom, 32'h0, 7'd0);
    send_item(REQ_POP, 32'h0, 32'h0, 7'd65);
    send_item(REQ_POP, 32'h0, 32'h0, 7'd4);
    send_item(REQ_POP, 32'h0, 32'h0, 7'd1);

    // Water marks near 20 and 30 samples, single channel.
    reconfigure(500, 1, 40, 60);
    run_mixed(60);

    tx_idle_pct = 84;
    rx_idle_pct = 37;
    reconfigure(1000, 2, 10, 20);
    run_mixed(30);
    drain();
    run_mixed(30);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    reconfigure(192000, 3, 65535, 65535);
    run_mixed(20);
    reconfigure(0, 0, 0, 0);
    run_mixed(15);

    // Climb past both marks (10 and 20 samples), refuse an oversized pop, then empty again.
    reconfigure(20, 1, 500, 1000);
    send_item(REQ_FLUSH, 32'h0, 32'h0, 7'd0);
    repeat (24) send_item(REQ_PUSH, $urandom,
                          ($urandom_range(1) ? 32'(flushes) : 32'h0), 7'd0);
    send_item(REQ_PUSH, $urandom, 32'(flushes + 7), 7'd0);
    send_item(REQ_POP, 32'h0, 32'h0, 7'h7F);
    send_item(REQ_POP, 32'h0, 32'h0, 7'd20);
    send_item(REQ_POP, 32'h0, 32'h0, 7'd4);
    send_item(REQ_FLUSH, 32'h0, 32'h0, 7'd0);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/asfw_pkg.sv
sv/audio_sample_fifo_watermarks_top.sv
sv/asfw_checker.sv
sim/audio_fifo_checker.sv
sim/audio_sample_fifo_watermarks_top_tb.sv
